// File: src/ihs_pkg.sv
package ihs_pkg;
   localparam int WinLen = 30;
   localparam int CountW = 6;
   localparam logic [CountW-1:0] CountMax = 6'd63;

   typedef logic [7:0] byte_type;

   typedef enum logic [6:0] {
      JP_SCAN = 7'b0000001,
      JP_MARK = 7'b0000010,
      JP_LENH = 7'b0000100,
      JP_LENL = 7'b0001000,
      JP_SKIP = 7'b0010000,
      JP_SOF  = 7'b0100000,
      JP_STOP = 7'b1000000
   } jp_state_type;

   typedef enum logic [2:0] {
      XP_SEARCH = 3'b001,
      XP_FOUND  = 3'b010,
      XP_FAIL   = 3'b100
   } xp_state_type;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_JPEG = 3'd1;
   localparam logic [2:0] KIND_PNG  = 3'd2;
   localparam logic [2:0] KIND_GIF  = 3'd3;
   localparam logic [2:0] KIND_WEBP = 3'd4;
   localparam logic [2:0] KIND_XML  = 3'd5;

   // status handed from the byte tracker to the result builder
   typedef struct packed {
      logic       jpeg_found;
      logic       xml_found;
      logic [CountW-1:0] len;
   } scan_status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] width;
      logic [31:0] height;
      logic [7:0]  channels;
      logic        mono_flag;
      logic        alpha_flag;
   } result_type;
endpackage

// File: src/ihs_if.sv
interface ihs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ihs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] width;
   logic [31:0] height;
   logic [7:0]  channels;
   logic        mono_flag;
   logic        alpha_flag;
   modport source (output valid, kind, width, height, channels, mono_flag, alpha_flag,
                   input ready);
   modport sink (input valid, kind, width, height, channels, mono_flag, alpha_flag,
                 output ready);
endinterface

// File: src/ihs_result.sv
// Decode the format and header fields from the captured window.
module ihs_result (
   input  ihs_pkg::byte_type        win [ihs_pkg::WinLen],
   input  ihs_pkg::byte_type        sof [6],
   input  ihs_pkg::scan_status_type stat,
   output ihs_pkg::result_type      res
);
   function automatic logic [31:0] le16(input ihs_pkg::byte_type a, input ihs_pkg::byte_type b);
      le16 = {16'd0, b, a};
   endfunction

   logic [31:0] bits;
   logic [5:0]  n;

   always_comb begin
      n = stat.len;
      bits = {win[24], win[23], win[22], win[21]};
      res = '0;
      if (n < 6'd4) begin
         res.kind = ihs_pkg::KIND_NONE;
      end else if (win[0] == 8'hFF && win[1] == 8'hD8 && win[2] == 8'hFF) begin
         res.kind = ihs_pkg::KIND_JPEG;
         if (stat.jpeg_found) begin
            res.height = {16'd0, sof[1], sof[2]};
            res.width = {16'd0, sof[3], sof[4]};
            res.channels = sof[5];
            res.mono_flag = (sof[5] == 8'd1);
         end
      end else if (n >= 6'd8 && win[0] == 8'h89 && win[1] == "P" && win[2] == "N"
                   && win[3] == "G" && win[4] == 8'h0D && win[5] == 8'h0A
                   && win[6] == 8'h1A && win[7] == 8'h0A) begin
         res.kind = ihs_pkg::KIND_PNG;
         if (n >= 6'd29 && win[12] == "I" && win[13] == "H" && win[14] == "D"
             && win[15] == "R") begin
            res.width = {win[16], win[17], win[18], win[19]};
            res.height = {win[20], win[21], win[22], win[23]};
            case (win[25])
               8'd0: begin res.channels = 8'd1; res.mono_flag = 1'b1; end
               8'd2, 8'd3: res.channels = 8'd3;
               8'd4: begin
                  res.channels = 8'd2; res.mono_flag = 1'b1; res.alpha_flag = 1'b1;
               end
               8'd6: begin res.channels = 8'd4; res.alpha_flag = 1'b1; end
               default: res.channels = 8'd0;
            endcase
         end
      end else if (n >= 6'd6 && win[0] == "G" && win[1] == "I" && win[2] == "F"
                   && win[3] == "8" && (win[4] == "7" || win[4] == "9") && win[5] == "a") begin
         res.kind = ihs_pkg::KIND_GIF;
         if (n >= 6'd10) begin
            res.width = le16(win[6], win[7]);
            res.height = le16(win[8], win[9]);
            res.channels = 8'd3;
         end
      end else if (n >= 6'd12 && win[0] == "R" && win[1] == "I" && win[2] == "F"
                   && win[3] == "F" && win[8] == "W" && win[9] == "E" && win[10] == "B"
                   && win[11] == "P") begin
         res.kind = ihs_pkg::KIND_WEBP;
         if (n >= 6'd30 && win[12] == "V" && win[13] == "P" && win[14] == "8") begin
            if (win[15] == " ") begin
               if (win[23] == 8'h9D && win[24] == 8'h01 && win[25] == 8'h2A) begin
                  res.width = le16(win[26], win[27]) & 32'h3FFF;
                  res.height = le16(win[28], win[29]) & 32'h3FFF;
                  res.channels = 8'd3;
               end
            end else if (win[15] == "L") begin
               if (win[20] == 8'h2F) begin
                  res.width = {18'd0, bits[13:0]} + 32'd1;
                  res.height = {18'd0, bits[27:14]} + 32'd1;
                  res.channels = 8'd3;
                  res.alpha_flag = bits[28];
               end
            end else if (win[15] == "X") begin
               res.alpha_flag = win[20][4];
               res.width = {8'd0, win[26], win[25], win[24]} + 32'd1;
               res.height = {8'd0, win[29], win[28], win[27]} + 32'd1;
               res.channels = 8'd3;
            end
         end
      end else if (stat.xml_found) begin
         res.kind = ihs_pkg::KIND_XML;
      end
   end
endmodule

// File: src/image_header_sniffer.sv
// Image header sniffer. Feed a file one byte per word on req_, marking the final byte
// with last_byte; one result word appears on rsp_ for that file, giving the format
// (JPEG, PNG, GIF, WebP, XML or unknown) and width, height, channel count, grayscale
// and alpha flags where the header holds them. One byte is taken every cycle; the
// per-byte state update (JPEG segment walker, XML prefix tracker, 30-byte header
// window) sits before the input boundary and the format decode sits between a
// registered snapshot and the result register. Input stalls only while both the
// snapshot and the result register hold a result and the result is not being taken.
module image_header_sniffer (
   input logic clock,
   input logic reset,
   ihs_req_if.sink   req_bus,
   ihs_rsp_if.source rsp_bus
);
   ihs_pkg::byte_type win_ff [ihs_pkg::WinLen];
   ihs_pkg::byte_type sof_ff [6];
   ihs_pkg::byte_type swin_ff [ihs_pkg::WinLen];
   ihs_pkg::byte_type ssof_ff [6];
   logic [5:0]  count_ff;
   ihs_pkg::jp_state_type jp_ff, jp_in;
   ihs_pkg::xp_state_type xp_ff, xp_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  marker_ff, marker_in;
   logic [2:0]  sidx_ff, sidx_in;
   logic        found_ff, found_in;
   logic        sval_ff;
   ihs_pkg::scan_status_type stat_ff;
   logic        rval_ff;
   ihs_pkg::result_type res_ff, res_c;
   logic        take, s_adv, sof_wr, first_ef;
   logic [15:0] seg;
   logic [7:0]  b;
   logic [4:0]  widx;

   // stage 2 advances when result register is free or being drained
   assign s_adv = !rval_ff || rsp_bus.ready;
   assign req_bus.ready = !sval_ff || s_adv;
   assign take = req_bus.valid && req_bus.ready;
   assign b = req_bus.data_byte;
   assign seg = skip_ff | {8'd0, b};
   assign widx = count_ff[4:0];
   // first byte is a possible BOM: window slot 0 holds it once count passes zero
   assign first_ef = (count_ff == 6'd0) ? (b == 8'hEF) : (win_ff[0] == 8'hEF);

   always_comb begin
      jp_in = jp_ff;
      skip_in = skip_ff;
      marker_in = marker_ff;
      sidx_in = sidx_ff;
      found_in = found_ff;
      sof_wr = 1'b0;
      if (count_ff >= 6'd2) begin
         case (jp_ff)
            ihs_pkg::JP_SCAN: if (b == 8'hFF) jp_in = ihs_pkg::JP_MARK;
            ihs_pkg::JP_MARK: begin
               if (b == 8'hFF) begin
                  jp_in = ihs_pkg::JP_MARK;
               end else if (b == 8'hD8 || b inside {[8'hD0:8'hD7]} || b == 8'h01) begin
                  jp_in = ihs_pkg::JP_SCAN;
               end else if (b == 8'hDA || b == 8'hD9) begin
                  jp_in = ihs_pkg::JP_STOP;
               end else begin
                  marker_in = b;
                  jp_in = ihs_pkg::JP_LENH;
               end
            end
            ihs_pkg::JP_LENH: begin
               skip_in = {b, 8'd0};
               jp_in = ihs_pkg::JP_LENL;
            end
            ihs_pkg::JP_LENL: begin
               if (seg < 16'd2) begin
                  jp_in = ihs_pkg::JP_STOP;
               end else if (marker_ff inside {[8'hC0:8'hCF]} && marker_ff != 8'hC4
                            && marker_ff != 8'hC8 && marker_ff != 8'hCC) begin
                  sidx_in = 3'd0;
                  jp_in = ihs_pkg::JP_SOF;
               end else if (seg == 16'd2) begin
                  skip_in = 16'd0;
                  jp_in = ihs_pkg::JP_SCAN;
               end else begin
                  skip_in = seg - 16'd2;
                  jp_in = ihs_pkg::JP_SKIP;
               end
            end
            ihs_pkg::JP_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) jp_in = ihs_pkg::JP_SCAN;
            end
            ihs_pkg::JP_SOF: begin
               sof_wr = 1'b1;
               sidx_in = sidx_ff + 3'd1;
               if (sidx_ff == 3'd5) begin
                  found_in = 1'b1;
                  jp_in = ihs_pkg::JP_STOP;
               end
            end
            default: jp_in = jp_ff;
         endcase
      end
   end

   always_comb begin
      xp_in = xp_ff;
      if (xp_ff == ihs_pkg::XP_SEARCH) begin
         if (count_ff == 6'd0 && b == 8'hEF) begin
            xp_in = ihs_pkg::XP_SEARCH;
         end else if ((count_ff == 6'd1 || count_ff == 6'd2) && first_ef) begin
            if (b != ((count_ff == 6'd1) ? 8'hBB : 8'hBF)) xp_in = ihs_pkg::XP_FAIL;
         end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
            xp_in = ihs_pkg::XP_SEARCH;
         end else begin
            xp_in = (b == 8'h3C) ? ihs_pkg::XP_FOUND : ihs_pkg::XP_FAIL;
         end
      end
   end

   // hold window and SOF bytes; they are payload and need no reset
   always_ff @(posedge clock) begin
      if (take && count_ff < 6'(ihs_pkg::WinLen)) win_ff[widx] <= b;
      if (take && sof_wr) sof_ff[sidx_ff] <= b;
      if (take && req_bus.last_byte) begin
         // snapshot the window with the final byte merged in
         for (int k = 0; k < ihs_pkg::WinLen; k++)
            swin_ff[k] <= (count_ff < 6'(ihs_pkg::WinLen) && widx == 5'(k)) ? b : win_ff[k];
         for (int k = 0; k < 6; k++)
            ssof_ff[k] <= (sof_wr && sidx_ff == 3'(k)) ? b : sof_ff[k];
      end
      if (sval_ff && s_adv) res_ff <= res_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         jp_ff <= ihs_pkg::JP_SCAN;
         xp_ff <= ihs_pkg::XP_SEARCH;
         skip_ff <= '0;
         marker_ff <= '0;
         sidx_ff <= '0;
         found_ff <= 1'b0;
         sval_ff <= 1'b0;
         stat_ff <= '0;
         rval_ff <= 1'b0;
      end else begin
         if (take) begin
            if (req_bus.last_byte) begin
               // drop per-file state, ready for the next file
               count_ff <= '0;
               jp_ff <= ihs_pkg::JP_SCAN;
               xp_ff <= ihs_pkg::XP_SEARCH;
               skip_ff <= '0;
               marker_ff <= '0;
               sidx_ff <= '0;
               found_ff <= 1'b0;
               stat_ff.jpeg_found <= found_in;
               stat_ff.xml_found <= (xp_in == ihs_pkg::XP_FOUND);
               stat_ff.len <= (count_ff == ihs_pkg::CountMax) ? count_ff : count_ff + 6'd1;
            end else begin
               if (count_ff != ihs_pkg::CountMax) count_ff <= count_ff + 6'd1;
               jp_ff <= jp_in;
               xp_ff <= xp_in;
               skip_ff <= skip_in;
               marker_ff <= marker_in;
               sidx_ff <= sidx_in;
               found_ff <= found_in;
            end
         end
         if (take && req_bus.last_byte) sval_ff <= 1'b1;
         else if (s_adv) sval_ff <= 1'b0;
         if (s_adv) rval_ff <= sval_ff;
      end
   end

   ihs_result u_result (.win(swin_ff), .sof(ssof_ff), .stat(stat_ff), .res(res_c));

   assign rsp_bus.valid = rval_ff;
   assign rsp_bus.kind = res_ff.kind;
   assign rsp_bus.width = res_ff.width;
   assign rsp_bus.height = res_ff.height;
   assign rsp_bus.channels = res_ff.channels;
   assign rsp_bus.mono_flag = res_ff.mono_flag;
   assign rsp_bus.alpha_flag = res_ff.alpha_flag;

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rval_ff |-> res_ff.kind <= ihs_pkg::KIND_XML) else $error("kind out of range");
   a_sof_found: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> jp_ff == ihs_pkg::JP_STOP) else $error("sof found but walk not stopped");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rval_ff && !rsp_bus.ready |=> rval_ff) else $error("result dropped");
   a_no_empty_meta: assert property (@(posedge clock) disable iff (reset)
      rval_ff && (res_ff.kind == ihs_pkg::KIND_NONE || res_ff.kind == ihs_pkg::KIND_XML)
      |-> res_ff.width == 32'd0 && res_ff.channels == 8'd0) else $error("stray fields");
endmodule

// File: sim/image_header_sniffer_test.sv
module image_header_sniffer_test;
   logic clock;
   logic reset;

   ihs_req_if req_ch ();
   ihs_rsp_if rsp_ch ();

   image_header_sniffer uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_ch.sink),
      .rsp_bus(rsp_ch.source)
   );

   // clock and watchdog
   localparam int CycleLimit = 400000;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Predictor: a software copy of the sniffer state, advanced one
   // byte at a time as the bytes are accepted by the block.
   // ---------------------------------------------------------------
   typedef enum int {
      WALK_SCAN, WALK_MARK, WALK_LENH, WALK_LENL, WALK_SKIP, WALK_SOF, WALK_STOP
   } walk_phase_type;
   typedef enum int { PROLOG_SEARCH, PROLOG_FOUND, PROLOG_FAIL } prolog_phase_type;

   logic [5:0]        seen_count;
   ihs_pkg::byte_type window_bytes [ihs_pkg::WinLen];
   walk_phase_type    walk_phase;
   ihs_pkg::byte_type seg_marker;
   logic [15:0]       seg_left;
   int                sof_pos;
   ihs_pkg::byte_type sof_bytes [6];
   logic              sof_found;
   prolog_phase_type  prolog_phase;

   ihs_pkg::result_type expected_results [$];

   function automatic void clear_sniff_state();
      seen_count = '0;
      foreach (window_bytes[i]) window_bytes[i] = '0;
      walk_phase = WALK_SCAN;
      seg_marker = '0;
      seg_left = '0;
      sof_pos = 0;
      foreach (sof_bytes[i]) sof_bytes[i] = '0;
      sof_found = 1'b0;
      prolog_phase = PROLOG_SEARCH;
   endfunction

   function automatic bit is_sof(ihs_pkg::byte_type m);
      return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
   endfunction

   function automatic void walk_segments(ihs_pkg::byte_type b);
      logic [15:0] seg;
      case (walk_phase)
         WALK_SCAN: if (b == 8'hFF) walk_phase = WALK_MARK;
         WALK_MARK: begin
            if (b == 8'hFF) begin
            end else if (b == 8'hD8 || (b >= 8'hD0 && b <= 8'hD7) || b == 8'h01) begin
               walk_phase = WALK_SCAN;
            end else if (b == 8'hDA || b == 8'hD9) begin
               walk_phase = WALK_STOP;
            end else begin
               seg_marker = b;
               walk_phase = WALK_LENH;
            end
         end
         WALK_LENH: begin
            seg_left = {b, 8'h00};
            walk_phase = WALK_LENL;
         end
         WALK_LENL: begin
            seg = seg_left | {8'h00, b};
            if (seg < 16'd2) walk_phase = WALK_STOP;
            else if (is_sof(seg_marker)) begin
               sof_pos = 0;
               walk_phase = WALK_SOF;
            end else if (seg == 16'd2) begin
               seg_left = '0;
               walk_phase = WALK_SCAN;
            end else begin
               seg_left = seg - 16'd2;
               walk_phase = WALK_SKIP;
            end
         end
         WALK_SKIP: begin
            seg_left = seg_left - 16'd1;
            if (seg_left == 16'd0) walk_phase = WALK_SCAN;
         end
         WALK_SOF: begin
            sof_bytes[sof_pos] = b;
            sof_pos++;
            if (sof_pos >= 6) begin
               sof_found = 1'b1;
               walk_phase = WALK_STOP;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void track_prolog(ihs_pkg::byte_type b, int n);
      if (prolog_phase != PROLOG_SEARCH) return;
      if (n == 0 && b == 8'hEF) return;
      if ((n == 1 || n == 2) && window_bytes[0] == 8'hEF) begin
         if (b != (n == 1 ? 8'hBB : 8'hBF)) prolog_phase = PROLOG_FAIL;
         return;
      end
      if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) return;
      prolog_phase = (b == "<") ? PROLOG_FOUND : PROLOG_FAIL;
   endfunction

   function automatic bit window_has(int o, string s);
      for (int k = 0; k < s.len(); k++)
         if (window_bytes[o + k] != s[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] le_at(int o, int n);
      logic [31:0] v = '0;
      for (int k = n - 1; k >= 0; k--) v = (v << 8) | {24'd0, window_bytes[o + k]};
      return v;
   endfunction

   function automatic logic [31:0] be_at(int o, int n);
      logic [31:0] v = '0;
      for (int k = 0; k < n; k++) v = (v << 8) | {24'd0, window_bytes[o + k]};
      return v;
   endfunction

   // advance on one accepted byte; queue a result on the last byte
   function automatic void sniff_byte(ihs_pkg::byte_type b, logic last);
      int n;
      int len;
      ihs_pkg::result_type r;
      logic [31:0] bits;
      n = int'(seen_count);
      if (n < ihs_pkg::WinLen) window_bytes[n] = b;
      if (n >= 2) walk_segments(b);
      track_prolog(b, n);
      if (seen_count != ihs_pkg::CountMax) seen_count = seen_count + 6'd1;
      if (!last) return;
      len = int'(seen_count);
      r = '0;
      if (len < 4) begin
         r.kind = ihs_pkg::KIND_NONE;
      end else if (window_bytes[0] == 8'hFF && window_bytes[1] == 8'hD8 &&
                   window_bytes[2] == 8'hFF) begin
         r.kind = ihs_pkg::KIND_JPEG;
         if (sof_found) begin
            r.height = {16'd0, sof_bytes[1], sof_bytes[2]};
            r.width = {16'd0, sof_bytes[3], sof_bytes[4]};
            r.channels = sof_bytes[5];
            r.mono_flag = (sof_bytes[5] == 8'd1);
         end
      end else if (len >= 8 && window_has(0, "\x89PNG\r\n\x1a\n")) begin
         r.kind = ihs_pkg::KIND_PNG;
         if (len >= 29 && window_has(12, "IHDR")) begin
            r.width = be_at(16, 4);
            r.height = be_at(20, 4);
            case (window_bytes[25])
               8'd0: begin r.channels = 8'd1; r.mono_flag = 1'b1; end
               8'd2, 8'd3: r.channels = 8'd3;
               8'd4: begin r.channels = 8'd2; r.mono_flag = 1'b1; r.alpha_flag = 1'b1; end
               8'd6: begin r.channels = 8'd4; r.alpha_flag = 1'b1; end
               default: ;
            endcase
         end
      end else if (len >= 6 && (window_has(0, "GIF87a") || window_has(0, "GIF89a"))) begin
         r.kind = ihs_pkg::KIND_GIF;
         if (len >= 10) begin
            r.width = le_at(6, 2);
            r.height = le_at(8, 2);
            r.channels = 8'd3;
         end
      end else if (len >= 12 && window_has(0, "RIFF") && window_has(8, "WEBP")) begin
         r.kind = ihs_pkg::KIND_WEBP;
         if (len >= 30) begin
            if (window_has(12, "VP8 ")) begin
               if (window_bytes[23] == 8'h9D && window_bytes[24] == 8'h01 &&
                   window_bytes[25] == 8'h2A) begin
                  r.width = le_at(26, 2) & 32'h3FFF;
                  r.height = le_at(28, 2) & 32'h3FFF;
                  r.channels = 8'd3;
               end
            end else if (window_has(12, "VP8L")) begin
               if (window_bytes[20] == 8'h2F) begin
                  bits = le_at(21, 4);
                  r.width = (bits & 32'h3FFF) + 32'd1;
                  r.height = ((bits >> 14) & 32'h3FFF) + 32'd1;
                  r.channels = 8'd3;
                  r.alpha_flag = bits[28];
               end
            end else if (window_has(12, "VP8X")) begin
               r.alpha_flag = window_bytes[20][4];
               r.width = le_at(24, 3) + 32'd1;
               r.height = le_at(27, 3) + 32'd1;
               r.channels = 8'd3;
            end
         end
      end else if (prolog_phase == PROLOG_FOUND) begin
         r.kind = ihs_pkg::KIND_XML;
      end
      expected_results.push_back(r);
      clear_sniff_state();
   endfunction

   // ---------------------------------------------------------------
   // Sender: one byte word per call, with random gaps
   // ---------------------------------------------------------------
   int  bytes_sent = 0;
   int  files_sent = 0;
   bit  sender_gaps = 1'b1;

   function automatic int pick_gap();
      int roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // valid stays high after acceptance; the next call drops it for a gap or
   // offers its own word at this same edge
   task automatic send_byte(ihs_pkg::byte_type b, logic last);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // accepted at this edge
      sniff_byte(b, last);
      bytes_sent++;
      if (last) files_sent++;
   endtask

   task automatic send_file(ihs_pkg::byte_type bytes_q [$]);
      foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   // ---------------------------------------------------------------
   // Receiver: random ready, with an optional long hold-off
   // ---------------------------------------------------------------
   int  holdoff_cycles = 0;
   bit  sink_gaps = 1'b1;
   int  sink_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait <= sink_wait - 1;
         rsp_ch.ready <= 1'b0;
      end else if (sink_gaps && rsp_ch.ready && $urandom_range(0, 99) < 30) begin
         sink_wait <= pick_gap();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Checker: compare each result word with the oldest expectation
   // ---------------------------------------------------------------
   int mismatch_count = 0;
   int results_seen = 0;
   int kind_hits [6];

   task automatic report_mismatch(string what, ihs_pkg::result_type exp_r,
                                  ihs_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"mismatch %s: expected kind=%0d w=%0d h=%0d ch=%0d g=%0b a=%0b, ",
                   "got kind=%0d w=%0d h=%0d ch=%0d g=%0b a=%0b"},
                  what, exp_r.kind, exp_r.width, exp_r.height, exp_r.channels,
                  exp_r.mono_flag, exp_r.alpha_flag, got.kind, got.width,
                  got.height, got.channels, got.mono_flag, got.alpha_flag);
   endtask

   always @(posedge clock) begin
      ihs_pkg::result_type got;
      ihs_pkg::result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind = rsp_ch.kind;
         got.width = rsp_ch.width;
         got.height = rsp_ch.height;
         got.channels = rsp_ch.channels;
         got.mono_flag = rsp_ch.mono_flag;
         got.alpha_flag = rsp_ch.alpha_flag;
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.kind <= ihs_pkg::KIND_XML) kind_hits[exp_r.kind]++;
            if (got.kind !== exp_r.kind) report_mismatch("kind", exp_r, got);
            else if (got.width !== exp_r.width) report_mismatch("width", exp_r, got);
            else if (got.height !== exp_r.height) report_mismatch("height", exp_r, got);
            else if (got.channels !== exp_r.channels) report_mismatch("channels", exp_r, got);
            else if (got.mono_flag !== exp_r.mono_flag)
               report_mismatch("grayscale", exp_r, got);
            else if (got.alpha_flag !== exp_r.alpha_flag) report_mismatch("alpha", exp_r, got);
         end
      end
   end

   // ---------------------------------------------------------------
   // File builders
   // ---------------------------------------------------------------
   function automatic void push_str(ref ihs_pkg::byte_type q [$], input string s);
      for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
   endfunction

   function automatic void push_le(ref ihs_pkg::byte_type q [$], input logic [31:0] v,
                                   input int n);
      for (int k = 0; k < n; k++) q.push_back(v[8*k +: 8]);
   endfunction

   function automatic void push_be(ref ihs_pkg::byte_type q [$], input logic [31:0] v,
                                   input int n);
      for (int k = n - 1; k >= 0; k--) q.push_back(v[8*k +: 8]);
   endfunction

   function automatic void push_random(ref ihs_pkg::byte_type q [$], input int n);
      repeat (n) q.push_back(ihs_pkg::byte_type'($urandom));
   endfunction

   // cut a file short now and then, to reach the truncated-header paths
   function automatic void maybe_cut(ref ihs_pkg::byte_type q [$]);
      int keep;
      if ($urandom_range(0, 99) < 15 && q.size() > 1) begin
         keep = $urandom_range(1, q.size() - 1);
         while (q.size() > keep) void'(q.pop_back());
      end
   endfunction

   function automatic void build_png(ref ihs_pkg::byte_type q [$], input int color,
                                     input bit good_chunk);
      push_str(q, "\x89PNG\r\n\x1a\n");
      push_be(q, 32'd13, 4);
      push_str(q, good_chunk ? "IHDR" : "IDAT");
      push_be(q, $urandom, 4);
      push_be(q, $urandom, 4);
      q.push_back(8'd8);
      q.push_back(ihs_pkg::byte_type'(color));
      push_random(q, $urandom_range(3, 10));
   endfunction

   function automatic void build_gif(ref ihs_pkg::byte_type q [$]);
      push_str(q, $urandom_range(0, 1) ? "GIF89a" : "GIF87a");
      push_le(q, $urandom, 2);
      push_le(q, $urandom, 2);
      push_random(q, $urandom_range(0, 8));
   endfunction

   function automatic void build_webp(ref ihs_pkg::byte_type q [$], input int flavor);
      push_str(q, "RIFF");
      push_le(q, $urandom, 4);
      push_str(q, "WEBP");
      case (flavor)
         0: begin
            push_str(q, "VP8 ");
            push_random(q, 7);
            if ($urandom_range(0, 5) != 0) begin
               q.push_back(8'h9D); q.push_back(8'h01); q.push_back(8'h2A);
            end else push_random(q, 3);
            push_le(q, $urandom, 4);
         end
         1: begin
            push_str(q, "VP8L");
            push_random(q, 4);
            q.push_back($urandom_range(0, 5) != 0 ? 8'h2F : ihs_pkg::byte_type'($urandom));
            push_le(q, $urandom, 4);
            q.push_back(ihs_pkg::byte_type'($urandom));
         end
         2: begin
            push_str(q, "VP8X");
            push_random(q, 4);
            push_random(q, 14);
         end
         default: push_random(q, 18);
      endcase
      push_random(q, $urandom_range(0, 6));
   endfunction

   function automatic void build_jpeg(ref ihs_pkg::byte_type q [$]);
      int segs;
      int len;
      ihs_pkg::byte_type m;
      q.push_back(8'hFF); q.push_back(8'hD8);
      segs = $urandom_range(0, 3);
      repeat (segs) begin
         q.push_back(8'hFF);
         if ($urandom_range(0, 4) == 0) q.push_back(8'hFF);          // fill byte
         if ($urandom_range(0, 5) == 0) begin
            q.push_back(ihs_pkg::byte_type'($urandom_range(8'hD0, 8'hD7)));  // standalone
         end else begin
            m = $urandom_range(0, 1) ? 8'hC4
                                     : ihs_pkg::byte_type'($urandom_range(8'hE0, 8'hEF));
            q.push_back(m);
            len = $urandom_range(2, 12);
            push_be(q, len, 2);
            push_random(q, len - 2);
         end
      end
      case ($urandom_range(0, 9))
         0: begin q.push_back(8'hFF); q.push_back(8'hDA); end
         1: begin q.push_back(8'hFF); q.push_back(8'hD9); end
         2: begin
            q.push_back(8'hFF); q.push_back(8'hE1); push_be(q, $urandom_range(0, 1), 2);
         end
         default: begin
            q.push_back(8'hFF);
            m = ihs_pkg::byte_type'($urandom_range(8'hC0, 8'hCF));
            if (m == 8'hC4 || m == 8'hC8 || m == 8'hCC) m = 8'hC0;
            q.push_back(m);
            push_be(q, 17, 2);
            q.push_back(8'd8);
            push_be(q, $urandom, 2);
            push_be(q, $urandom, 2);
            q.push_back($urandom_range(0, 1) ? ihs_pkg::byte_type'($urandom_range(1, 4))
                                             : ihs_pkg::byte_type'($urandom));
         end
      endcase
      push_random(q, $urandom_range(0, 6));
   endfunction

   function automatic void build_xml(ref ihs_pkg::byte_type q [$]);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) begin q.push_back(8'hEF); q.push_back(8'hBB); q.push_back(8'hBF); end
      if (r == 1) begin q.push_back(8'hEF); q.push_back(ihs_pkg::byte_type'($urandom)); end
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 3))
            0: q.push_back(" ");
            1: q.push_back(8'h09);
            2: q.push_back(8'h0D);
            default: q.push_back(8'h0A);
         endcase
      end
      q.push_back($urandom_range(0, 5) != 0 ? ihs_pkg::byte_type'("<")
                                            : ihs_pkg::byte_type'($urandom));
      push_str(q, "?xml");
      push_random(q, $urandom_range(0, 5));
   endfunction

   function automatic void build_any(ref ihs_pkg::byte_type q [$]);
      case ($urandom_range(0, 11))
         0, 1:    build_jpeg(q);
         2, 3:    build_png(q, $urandom_range(0, 7), $urandom_range(0, 7) != 0);
         4:       build_gif(q);
         5, 6:    build_webp(q, $urandom_range(0, 3));
         7:       build_xml(q);
         8:       push_random(q, $urandom_range(1, 12));
         9:       push_random(q, $urandom_range(64, 80));   // count saturates
         default: begin
            build_jpeg(q);
            if ($urandom_range(0, 1)) push_random(q, 50);
         end
      endcase
      maybe_cut(q);
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      ihs_pkg::byte_type q [$];
      // short file of one byte and of three bytes
      q = {}; q.push_back(8'hFF); send_file(q);
      q = {}; q.push_back(8'hFF); q.push_back(8'hD8); q.push_back(8'hFF); send_file(q);
      // no match, all zeros and all ones
      q = {}; repeat (5) q.push_back(8'h00); send_file(q);
      q = {}; repeat (5) q.push_back(8'hFF); send_file(q);
      // PNG every colour type, wrong chunk, cut short
      for (int c = 0; c <= 7; c++) begin q = {}; build_png(q, c, 1'b1); send_file(q); end
      q = {}; build_png(q, 2, 1'b0); send_file(q);
      q = {}; build_png(q, 6, 1'b1); while (q.size() > 28) void'(q.pop_back()); send_file(q);
      // GIF full and cut before dimensions
      q = {}; build_gif(q); send_file(q);
      q = {}; push_str(q, "GIF89a"); push_le(q, 32'hFFFF, 2); q.push_back(8'h01); send_file(q);
      // WebP each chunk, unknown chunk, cut short
      for (int f = 0; f < 4; f++) begin q = {}; build_webp(q, f); send_file(q); end
      q = {}; build_webp(q, 2); while (q.size() > 29) void'(q.pop_back()); send_file(q);
      // random JPEG, mostly with SOF, and one without
      q = {}; build_jpeg(q); send_file(q);
      q = {}; q.push_back(8'hFF); q.push_back(8'hD8); q.push_back(8'hFF); q.push_back(8'hD9);
      send_file(q);
      // XML with BOM, and broken BOM
      q = {}; push_str(q, "\xEF\xBB\xBF \t\r\n<a>"); send_file(q);
      q = {}; q.push_back(8'hEF); q.push_back(8'h00); push_str(q, "<a>"); send_file(q);
      // long file past the count limit
      q = {}; push_random(q, 70); send_file(q);
   endtask

   task automatic test_random(int byte_budget);
      ihs_pkg::byte_type q [$];
      int stop_at;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         q = {};
         build_any(q);
         send_file(q);
      end
   endtask

   task automatic test_backpressure();
      ihs_pkg::byte_type q [$];
      // hold the receiver off while short files keep coming
      holdoff_cycles = 300;
      sender_gaps = 1'b0;
      repeat (8) begin
         q = {};
         push_str(q, "GIF87a");
         push_random(q, 4);
         send_file(q);
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_no_gaps();
      sender_gaps = 1'b0;
      sink_gaps = 1'b0;
      test_random(40);
      sender_gaps = 1'b1;
      sink_gaps = 1'b1;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      clear_sniff_state();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(50);
      test_no_gaps();
      drain();

      $display("sent %0d bytes in %0d files, checked %0d results", bytes_sent, files_sent,
               results_seen);
      $display("kinds seen: none=%0d jpeg=%0d png=%0d gif=%0d webp=%0d xml=%0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
               kind_hits[5]);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end
endmodule

// File: files.f
src/ihs_pkg.sv
src/ihs_if.sv
src/ihs_result.sv
src/image_header_sniffer.sv
sim/image_header_sniffer_test.sv
